// File: src/bba_pkg.sv
// Shared types, constants and control bundles for the bitmap block allocator.
package bba_pkg;

	// Map geometry
	localparam int MAP_WORDS  = 128;
	localparam int WORD_BITS  = 32;
	localparam int ADDR_WORDS = 128;
	localparam int INDEX_W    = 12;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WORD_IDX_W = INDEX_W - BIT_W;
	localparam int SCAN_WORDS = (MAP_WORDS < ADDR_WORDS) ? MAP_WORDS : ADDR_WORDS;
	localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W      = $clog2(MAP_WORDS + 1);

	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	// Operation codes
	localparam logic [1:0] OP_FIND  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [INDEX_W-1:0] bit_index;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] free_index;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load_cmd;
		logic clr_step;
		logic scan_step;
		logic rmw_rd;
		logic rmw_wr;
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_hit;
		logic scan_end;
	} dp_sts_t;

endpackage

// File: src/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: controller, datapath and result register.
//
// Keeps a 4096-bit allocation map (128 words of 32 bits, 1 = used) in a
// single-port memory with registered read. Each item on the cmd channel is one
// operation: find the lowest free bit, set a bit used, or clear a bit free;
// every item yields exactly one item on the rsp channel. A find answers with
// found = 1 and the 0-based index of the lowest zero bit, or found = 0 and
// index 0 when the map is full; set, clear and the unused op code answer
// found = 0, index 0. A set or clear beyond the map changes nothing. After
// reset the block runs a clearing pass that writes every map word to zero,
// and holds cmd_stall high meanwhile. A find walks the map one word per
// cycle through the memory read port and stops at the first non-full word or
// at the end of the map; a set or clear is a read-modify-write of one word.
// One item is worked on at a time. The result register lets a new item be
// accepted while the previous result still waits on rsp_stall.
module bitmap_block_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bba_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bba_pkg::rsp_t rsp
);

	bba_pkg::dp_ctl_t ctl;
	bba_pkg::dp_sts_t sts;
	bba_pkg::rsp_t    result;
	logic             rsp_load;
	logic             slot_free;
	logic             rsp_valid_q;
	bba_pkg::rsp_t    rsp_q;

	// The result slot frees when empty or when its item leaves this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd.op),
		.slot_free (slot_free),
		.sts       (sts),
		.cmd_stall (cmd_stall),
		.rsp_load  (rsp_load),
		.ctl       (ctl)
	);

	bba_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

	// Hold the result until taken; drop valid once it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/bba_datapath.sv
// Datapath: map memory, word counter, read-modify-write and lowest-zero search.
module bba_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::cmd_t     cmd,
	input  bba_pkg::dp_ctl_t  ctl,
	output bba_pkg::dp_sts_t  sts,
	output bba_pkg::rsp_t     result
);

	// Encode a one-hot word to its bit position
	function automatic logic [bba_pkg::BIT_W-1:0] onehot_pos(
		input logic [bba_pkg::WORD_BITS-1:0] oh
	);
		logic [bba_pkg::BIT_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
			pos = pos | ({bba_pkg::BIT_W{oh[i]}} & bba_pkg::BIT_W'(i));
		end
		return pos;
	endfunction

	logic [bba_pkg::WORD_BITS-1:0] map_mem_q [bba_pkg::MAP_WORDS];
	logic [bba_pkg::WORD_BITS-1:0] rdata_q;
	logic [bba_pkg::CNT_W-1:0]     cnt_q;
	logic                          chk_q;
	logic [bba_pkg::CNT_W-1:0]     chk_word_q;
	bba_pkg::cmd_t                 cmd_q;
	bba_pkg::rsp_t                 res_q;

	logic [31:0]                   word_ext;
	logic                          in_range;
	logic [bba_pkg::MAP_AW-1:0]    word_addr;
	logic [bba_pkg::MAP_AW-1:0]    cnt_addr;
	logic [bba_pkg::WORD_BITS-1:0] bit_mask;
	logic                          scan_issue;
	logic                          rd_en;
	logic [bba_pkg::MAP_AW-1:0]    rd_addr;
	logic                          wr_en;
	logic [bba_pkg::MAP_AW-1:0]    wr_addr;
	logic [bba_pkg::WORD_BITS-1:0] wr_data;
	logic [bba_pkg::WORD_BITS-1:0] zeros;
	logic [bba_pkg::WORD_BITS-1:0] lowest_zero;
	logic                          hit;

	assign word_ext   = 32'(cmd_q.bit_index[bba_pkg::INDEX_W-1:bba_pkg::BIT_W]);
	assign in_range   = word_ext < 32'(bba_pkg::MAP_WORDS);
	assign word_addr  = word_ext[bba_pkg::MAP_AW-1:0];
	assign cnt_addr   = cnt_q[bba_pkg::MAP_AW-1:0];
	assign bit_mask   = bba_pkg::WORD_BITS'(1) << cmd_q.bit_index[bba_pkg::BIT_W-1:0];
	assign scan_issue = ctl.scan_step && (cnt_q < bba_pkg::CNT_W'(bba_pkg::SCAN_WORDS));

	always_comb begin
		rd_en   = scan_issue || (ctl.rmw_rd && in_range);
		rd_addr = ctl.rmw_rd ? word_addr : cnt_addr;
		wr_en   = ctl.clr_step || (ctl.rmw_wr && in_range);
		wr_addr = ctl.clr_step ? cnt_addr : word_addr;
		if (ctl.clr_step) begin
			wr_data = '0;
		end else if (cmd_q.op == bba_pkg::OP_SET) begin
			wr_data = rdata_q | bit_mask;
		end else begin
			wr_data = rdata_q & ~bit_mask;
		end
	end

	// Isolate the lowest zero bit of the word under check
	assign zeros       = ~rdata_q;
	assign lowest_zero = zeros & (~zeros + bba_pkg::WORD_BITS'(1));
	assign hit         = ctl.scan_step && chk_q && (rdata_q != bba_pkg::FULL_WORD);

	assign sts.clr_last = cnt_q == bba_pkg::CNT_W'(bba_pkg::MAP_WORDS - 1);
	assign sts.scan_hit = hit;
	assign sts.scan_end = (cnt_q == bba_pkg::CNT_W'(bba_pkg::SCAN_WORDS)) && !chk_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			chk_q <= 1'b0;
		end else begin
			chk_q <= scan_issue;
			if (ctl.load_cmd) begin
				cnt_q <= '0;
			end else if (ctl.clr_step || scan_issue) begin
				cnt_q <= cnt_q + bba_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			chk_word_q <= cnt_q;
		end
		if (ctl.load_cmd) begin
			cmd_q <= cmd;
			res_q <= '0;
		end else if (hit) begin
			res_q.found      <= 1'b1;
			res_q.free_index <= {bba_pkg::WORD_IDX_W'(chk_word_q), onehot_pos(lowest_zero)};
		end
	end

endmodule

// File: src/bba_ctrl.sv
// Controller state machine: clearing pass, command dispatch, scan and result handoff.
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        cmd_op,
	input  logic              slot_free,
	input  bba_pkg::dp_sts_t  sts,
	output logic              cmd_stall,
	output logic              rsp_load,
	output bba_pkg::dp_ctl_t  ctl
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_RMW_RD = 6'b001000,
		ST_RMW_WR = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load_cmd = 1'b1;
					priority if (cmd_op == bba_pkg::OP_FIND) begin
						state_d = ST_SCAN;
					end else if (cmd_op == bba_pkg::OP_SET || cmd_op == bba_pkg::OP_CLEAR) begin
						state_d = ST_RMW_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_RMW_RD: begin
				ctl.rmw_rd = 1'b1;
				state_d    = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				ctl.rmw_wr = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
